[rtl/clsf_pkg.sv]
// Package for the capped line step follower: shared constants, register
// indexes and the command and status structs between controller and datapath.
// No dependencies.
package clsf_pkg;

  // Upper bound on the number of one-pixel steps taken in one tick.
  localparam int MAX_STEPS = 64;
  // Step counter width; it must hold MAX_STEPS itself.
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  // Width of step number times minor distance.
  localparam int PROD_W    = STEP_W + 16;
  // Shift counter of the remainder unit, which runs STEP_W iterations.
  localparam int DIV_CNT_W = (STEP_W > 1) ? $clog2(STEP_W) : 1;

  localparam logic [15:0] NEUTRAL_ID    = 16'h0026;
  localparam logic [15:0] FIRST_ICON_ID = 16'h0029;
  localparam logic [15:0] OFFSET_X      = 16'h0022;
  localparam logic [15:0] OFFSET_Y      = 16'h0007;
  localparam logic [15:0] NONE_TRACKED  = 16'hFFFF;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ICONS_PRESENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ICON_COUNT    = 1'b1;

  typedef struct packed {
    logic                 load;
    logic                 eval;
    logic                 delta;
    logic                 mult;
    logic                 div;
    logic [DIV_CNT_W-1:0] div_sh;
    logic                 step;
    logic                 out_load;
  } clsf_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic walk_done;
  } clsf_stat_t;

endpackage

[rtl/capped_line_step_follower.sv]
// Top level of the capped line step follower: joins the controller and the
// datapath and presents the input, result and configuration channels.
// Depends on clsf_pkg, clsf_ctrl and clsf_datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    held_item, cursor_x, cursor_y, elapsed_ms
//   out      output     out_valid / out_stall  draw_icon, icon_index, icon_x, icon_y
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A tick walks at most MAX_STEPS steps, or none when no walk starts. Each
// step passes through a delta state, a multiply state, STEP_W iterations of
// the shift-subtract remainder unit and an update state.
// Reset is synchronous and active low; it clears the follower to the origin,
// marks no item as tracked and clears both configuration registers.
// The result sits in an output register, so a new input beat is taken while
// the previous result still waits on out_stall; the block only holds back in
// its final cycle if that register is still occupied.
module capped_line_step_follower (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [15:0]                     in_held_item,
  input  logic signed [15:0]              in_cursor_x,
  input  logic signed [15:0]              in_cursor_y,
  input  logic [15:0]                     in_elapsed_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_draw_icon,
  output logic [15:0]                     out_icon_index,
  output logic signed [15:0]              out_icon_x,
  output logic signed [15:0]              out_icon_y,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data
);

  clsf_pkg::clsf_cmd_t  cmd;
  clsf_pkg::clsf_stat_t stat;

  // Configuration registers are plain flops, so a write is always taken.
  assign cfg_ready = 1'b1;

  // The controller owns the handshakes and walks the step loop.
  clsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the follower state and computes each step.
  clsf_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_held_item   (in_held_item),
    .in_cursor_x    (in_cursor_x),
    .in_cursor_y    (in_cursor_y),
    .in_elapsed_ms  (in_elapsed_ms),
    .out_draw_icon  (out_draw_icon),
    .out_icon_index (out_icon_index),
    .out_icon_x     (out_icon_x),
    .out_icon_y     (out_icon_y)
  );

endmodule

[rtl/clsf_datapath.sv]
// Datapath of the capped line step follower: configuration registers,
// follower state, step deltas, the shift-subtract remainder unit and the
// result registers. Depends on clsf_pkg.
module clsf_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  clsf_pkg::clsf_cmd_t              cmd,
  output clsf_pkg::clsf_stat_t             stat,
  input  logic                             cfg_valid,
  input  logic [clsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                      cfg_data,
  input  logic [15:0]                      in_held_item,
  input  logic signed [15:0]               in_cursor_x,
  input  logic signed [15:0]               in_cursor_y,
  input  logic [15:0]                      in_elapsed_ms,
  output logic                             out_draw_icon,
  output logic [15:0]                      out_icon_index,
  output logic signed [15:0]               out_icon_x,
  output logic signed [15:0]               out_icon_y
);

  logic                              icons_present_r;
  logic [15:0]                       icon_count_r;
  logic [15:0]                       item_r;
  logic [15:0]                       tx_r;
  logic [15:0]                       ty_r;
  logic [clsf_pkg::STEP_W-1:0]       steps_r;
  logic [clsf_pkg::STEP_W-1:0]       i_r;
  logic [15:0]                       col_r;
  logic [15:0]                       row_r;
  logic [15:0]                       col_nxt;
  logic [15:0]                       row_nxt;
  logic [15:0]                       tracked_r;
  logic [15:0]                       r_r;
  logic [15:0]                       d_r;
  logic                              x_major_r;
  logic                              maj_neg_r;
  logic                              min_neg_r;
  logic [clsf_pkg::PROD_W-1:0]       rem_r;
  logic                              draw_r;
  logic [15:0]                       idx_r;
  logic [15:0]                       out_x_r;
  logic [15:0]                       out_y_r;

  logic                              active;
  logic [15:0]                       idx;
  logic                              in_range;
  logic                              on_target;
  logic [16:0]                       dx;
  logic [16:0]                       dy;
  logic [15:0]                       ax;
  logic [15:0]                       ay;
  logic [clsf_pkg::PROD_W-1:0]       dsh;
  logic [16:0]                       rem_sum;
  logic                              minor_move;
  logic [15:0]                       maj_inc;
  logic [15:0]                       min_inc;

  // Tick classification from the captured item.
  assign active    = (item_r != clsf_pkg::NEUTRAL_ID) && icons_present_r;
  assign idx       = item_r - clsf_pkg::FIRST_ICON_ID;
  assign in_range  = idx < icon_count_r;
  assign on_target = (col_r == tx_r) && (row_r == ty_r);

  assign stat.need_walk = active && in_range && (item_r == tracked_r) && !on_target &&
                          (steps_r != '0);
  assign stat.walk_done = (i_r == steps_r) || on_target;

  // Signed distances to the target at full precision.
  assign dx = {tx_r[15], tx_r} - {col_r[15], col_r};
  assign dy = {ty_r[15], ty_r} - {row_r[15], row_r};
  assign ax = dx[16] ? 16'(-dx) : dx[15:0];
  assign ay = dy[16] ? 16'(-dy) : dy[15:0];

  // Shifted divisor for one restoring iteration.
  assign dsh = clsf_pkg::PROD_W'(d_r) << cmd.div_sh;

  // The minor axis moves when the next remainder is larger, which with
  // r <= d means r != 0, r < d and rem + r < d.
  assign rem_sum    = {1'b0, rem_r[15:0]} + {1'b0, r_r};
  assign minor_move = (r_r != '0) && (r_r < d_r) && (rem_sum < {1'b0, d_r});
  assign maj_inc    = maj_neg_r ? 16'hFFFF : 16'h0001;
  assign min_inc    = minor_move ? (min_neg_r ? 16'hFFFF : 16'h0001) : 16'h0000;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.eval) begin
      if (active && in_range && (item_r != tracked_r)) begin
        col_nxt = tx_r;
        row_nxt = ty_r;
      end
    end else if (cmd.step) begin
      col_nxt = col_r + (x_major_r ? maj_inc : min_inc);
      row_nxt = row_r + (x_major_r ? min_inc : maj_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icons_present_r <= 1'b0;
      icon_count_r    <= '0;
      col_r           <= '0;
      row_r           <= '0;
      tracked_r       <= clsf_pkg::NONE_TRACKED;
    end else begin
      if (cfg_valid && (cfg_index == clsf_pkg::REG_ICONS_PRESENT)) begin
        icons_present_r <= cfg_data[0];
      end
      if (cfg_valid && (cfg_index == clsf_pkg::REG_ICON_COUNT)) begin
        icon_count_r <= cfg_data;
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cmd.eval) begin
        if (!active) begin
          tracked_r <= clsf_pkg::NONE_TRACKED;
        end else if (in_range) begin
          tracked_r <= item_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r  <= in_held_item;
      tx_r    <= 16'(in_cursor_x - clsf_pkg::OFFSET_X);
      ty_r    <= 16'(in_cursor_y - clsf_pkg::OFFSET_Y);
      steps_r <= (in_elapsed_ms > 16'(clsf_pkg::MAX_STEPS)) ?
                 clsf_pkg::STEP_W'(clsf_pkg::MAX_STEPS) :
                 in_elapsed_ms[clsf_pkg::STEP_W-1:0];
    end
    if (cmd.eval) begin
      i_r <= '0;
    end
    if (cmd.delta) begin
      x_major_r <= ax >= ay;
      r_r       <= (ax >= ay) ? ay : ax;
      d_r       <= (ax >= ay) ? ax : ay;
      maj_neg_r <= (ax >= ay) ? dx[16] : dy[16];
      min_neg_r <= (ax >= ay) ? dy[16] : dx[16];
    end
    if (cmd.mult) begin
      rem_r <= clsf_pkg::PROD_W'(i_r) * clsf_pkg::PROD_W'(r_r);
    end else if (cmd.div) begin
      if (rem_r >= dsh) begin
        rem_r <= rem_r - dsh;
      end
    end
    if (cmd.step) begin
      i_r <= i_r + 1'b1;
    end
    // The whole result beat is loaded together, so it stays put while stalled.
    if (cmd.out_load) begin
      draw_r  <= active && in_range;
      idx_r   <= (active && in_range) ? idx : 16'h0000;
      out_x_r <= col_r;
      out_y_r <= row_r;
    end
  end

  assign out_draw_icon  = draw_r;
  assign out_icon_index = idx_r;
  assign out_icon_x     = out_x_r;
  assign out_icon_y     = out_y_r;

  // The remainder unit must leave a value below the major distance.
  a_rem_below_major: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (rem_r < clsf_pkg::PROD_W'(d_r)))
    else $error("remainder not reduced below major distance");

  // A step is only taken while the step budget of the tick lasts.
  a_step_in_budget: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (i_r < steps_r))
    else $error("step taken beyond the step budget");

  // Each step moves the major axis by one pixel, so the position changes.
  a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> ((col_r != $past(col_r)) || (row_r != $past(row_r))))
    else $error("step left the follower in place");

endmodule

[rtl/clsf_ctrl.sv]
// Controller of the capped line step follower: sequences accept, evaluation,
// the per-step delta / multiply / remainder / update loop and result hand-off.
// Depends on clsf_pkg.
module clsf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  clsf_pkg::clsf_stat_t  stat,
  output clsf_pkg::clsf_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_DELTA = 3'd2;
  localparam logic [2:0] S_MULT  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_STEP  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                     state_r;
  logic [2:0]                     state_nxt;
  logic [clsf_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [clsf_pkg::DIV_CNT_W-1:0] div_cnt_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.div_sh    = div_cnt_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.need_walk ? S_DELTA : S_DONE;
      end
      S_DELTA: begin
        if (stat.walk_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.delta = 1'b1;
          state_nxt = S_MULT;
        end
      end
      S_MULT: begin
        cmd.mult    = 1'b1;
        div_cnt_nxt = clsf_pkg::DIV_CNT_W'(clsf_pkg::STEP_W - 1);
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = S_STEP;
        end else begin
          div_cnt_nxt = div_cnt_r - 1'b1;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_DELTA;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Once a beat is taken the block is busy with it on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again while the previous tick is in work");

endmodule
